/* rtl/pcs_pkg.sv */
// Shared types, constants and helpers for the percentile contrast stretch.
// Depends on nothing; pcs_div, pcs_core, the top level and the testbench import it.
package pcs_pkg;

    localparam int NUM_BINS  = 256;
    localparam int BIN_AW    = 8;
    localparam int PIX_W     = 8;
    localparam int CNT_W     = 25;
    localparam int PCT_W     = 14;
    localparam int ACC_W     = 47;
    localparam int THR_W     = 39;
    localparam int DIV_NW    = 20;
    localparam int DIV_DW    = 14;
    localparam int DIV_CW    = 6;
    localparam int Q_W       = 20;
    localparam int REM_W     = 10;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [CNT_W-1:0]  MAX_FRAME_PIXELS = 25'd16777216;
    localparam logic [DIV_DW-1:0] PCT_SCALE        = 14'd10000;
    localparam logic [ACC_W-1:0]  ACC_SEED         = 47'd9999;
    localparam logic [BIN_AW-1:0] BIN_LAST         = 8'hFF;
    localparam logic [PIX_W-1:0]  PIX_MAX          = 8'hFF;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_LOW_PCT  = 3'd0;
    localparam logic [2:0] REG_HIGH_PCT = 3'd1;
    localparam logic [2:0] REG_TGT_MIN  = 3'd2;
    localparam logic [2:0] REG_TGT_MAX  = 3'd3;
    localparam logic [2:0] REG_SKIP     = 3'd4;

    // Item kinds
    localparam logic MODE_HIST  = 1'b0;
    localparam logic MODE_APPLY = 1'b1;
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel_in;
        logic             frame_last;
    } t_in_item;

    typedef struct packed {
        logic             result_kind;
        logic [PIX_W-1:0] pixel_out;
        logic [PIX_W-1:0] low_cut;
        logic [PIX_W-1:0] high_cut;
        logic             full_range_fallback;
        logic [CNT_W-1:0] pixels_counted;
    } t_out_item;

    typedef struct packed {
        logic [PCT_W-1:0] low_percent_hundredths;
        logic [PCT_W-1:0] high_percent_hundredths;
        logic [PIX_W-1:0] target_min;
        logic [PIX_W-1:0] target_max;
        logic             skip_zero_pixels;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HUPD,
        S_AOUT,
        S_TMUL,
        S_SCAN,
        S_SETUP,
        S_QSDIV,
        S_QSWAIT,
        S_Q0DIV,
        S_Q0WAIT,
        S_FILL,
        S_REPORT
    } t_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= MAX_FRAME_PIXELS) ? MAX_FRAME_PIXELS : v + CNT_W'(1);
    endfunction

endpackage

/* rtl/pcs_chan_if.sv */
// Valid/ready stream channel carrying one request payload of type T.
// Depends on nothing; the payload type comes from the instantiating level.
interface pcs_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pcs_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pcs_pkg for operand widths.
module pcs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pcs_pkg::DIV_NW-1:0] i_dividend,
    input  logic [pcs_pkg::DIV_DW-1:0] i_divisor,
    output logic                       o_done,
    output logic [pcs_pkg::DIV_NW-1:0] o_quot,
    output logic [pcs_pkg::DIV_DW-1:0] o_rem
);
    import pcs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_div;
    logic [DIV_DW:0]   trial;
    logic              ge;

    assign trial = {r_rem, r_num[DIV_NW-1]};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NW-2:0], ge};
            r_rem <= ge ? DIV_DW'(trial - {1'b0, r_div}) : trial[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

/* rtl/pcs_core.sv */
// Sequencer with the histogram RAM and the stretch table RAM.
// Depends on pcs_pkg and instantiates pcs_div for the map slope and start value.
module pcs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcs_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pcs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pcs_pkg::t_out_item o_out_item
);
    import pcs_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0] hist_mem [NUM_BINS];
    logic [PIX_W-1:0] lut_mem  [NUM_BINS];
    logic [CNT_W-1:0] r_hist_q;
    logic [PIX_W-1:0] r_lut_q;

    t_in_item         r_item;
    logic [CNT_W-1:0] r_count;
    logic [BIN_AW:0]  r_idx;
    logic             r_dir;
    logic             r_pend;
    logic [BIN_AW-1:0] r_pend_addr;
    logic [ACC_W-1:0] r_acc;
    logic [THR_W-1:0] r_thr_lo, r_thr_hi;
    logic             r_tsel;
    logic             r_lo_found, r_hi_found;
    logic [PIX_W-1:0] r_lo_pos, r_hi_pos, r_lo, r_hi;
    logic             r_fb;
    logic signed [9:0] r_qs;
    logic [PIX_W-1:0] r_rs;
    logic signed [Q_W-1:0] r_q;
    logic [REM_W-1:0] r_rem;
    logic             r_out_valid;
    t_out_item        r_out;

    // FSM outputs
    logic              in_ready, out_free, out_load;
    logic              hist_we;
    logic [BIN_AW-1:0] hist_waddr, hist_raddr, scan_addr;
    logic [CNT_W-1:0]  hist_wdata;
    logic              counted, scan_issue, scan_end, div_start;
    logic [DIV_NW-1:0] div_dividend;
    logic [DIV_DW-1:0] div_divisor;
    logic              div_done;
    logic [DIV_NW-1:0] div_quot;
    logic [DIV_DW-1:0] div_rem;
    t_out_item         out_item;

    // Datapath helpers
    logic [ACC_W-1:0]      n_acc;
    logic                  hit;
    logic [PIX_W-1:0]      d;
    logic [PIX_W:0]        two_d;
    logic signed [PIX_W:0] span;
    logic [PIX_W-1:0]      span_mag;
    logic [15:0]           prod_md;
    logic signed [17:0]    prod_ls;
    logic signed [Q_W-1:0] num0;
    logic [Q_W-1:0]        num0_mag;
    logic [REM_W-1:0]      rem_sum;
    logic signed [Q_W-1:0] qs_ext;
    logic [PIX_W-1:0]      lut_wdata;
    logic                  accept;

    assign accept   = i_in_valid && in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign counted  = !(i_cfg.skip_zero_pixels && (r_item.pixel_in == '0));
    assign scan_end = r_idx[BIN_AW] && !r_pend;
    assign scan_addr = r_dir ? ~r_idx[BIN_AW-1:0] : r_idx[BIN_AW-1:0];

    // The running sum is kept as sum*10000 + 9999, so it reaches pct*count
    // exactly when the plain sum reaches floor(pct*count/10000)
    assign n_acc = r_acc + ACC_W'(r_hist_q) * ACC_W'(PCT_SCALE);
    assign hit   = (n_acc >= ACC_W'(r_dir ? r_thr_hi : r_thr_lo));

    assign d        = r_hi - r_lo;
    assign two_d    = {d, 1'b0};
    assign span     = $signed({1'b0, i_cfg.target_max}) - $signed({1'b0, i_cfg.target_min});
    assign span_mag = span[PIX_W] ? PIX_W'(-span) : span[PIX_W-1:0];
    assign prod_md  = i_cfg.target_min * d;
    assign prod_ls  = $signed({1'b0, r_lo}) * span;
    assign num0     = $signed(Q_W'(d)) + ($signed(Q_W'(prod_md)) <<< 1)
                    - (Q_W'(prod_ls) <<< 1);
    assign num0_mag = num0[Q_W-1] ? Q_W'(-num0) : Q_W'(num0);

    assign rem_sum = r_rem + REM_W'({r_rs, 1'b0});
    assign qs_ext  = Q_W'(r_qs);
    assign lut_wdata = r_q[Q_W-1] ? '0 : ((r_q > Q_W'(PIX_MAX)) ? PIX_MAX : r_q[PIX_W-1:0]);

    pcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_idx[BIN_AW-1:0] == BIN_LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) n_state = (i_in_item.mode == MODE_APPLY) ? S_AOUT : S_HUPD;
            end
            S_HUPD:   n_state = r_item.frame_last ? S_TMUL : S_IDLE;
            S_AOUT:   if (out_free) n_state = S_IDLE;
            S_TMUL:   n_state = r_tsel ? S_SCAN : S_TMUL;
            S_SCAN:   if (scan_end && r_dir) n_state = S_SETUP;
            S_SETUP:  n_state = S_QSDIV;
            S_QSDIV:  n_state = S_QSWAIT;
            S_QSWAIT: if (div_done) n_state = S_Q0DIV;
            S_Q0DIV:  n_state = S_Q0WAIT;
            S_Q0WAIT: if (div_done) n_state = S_FILL;
            S_FILL:   if (r_idx[BIN_AW-1:0] == BIN_LAST) n_state = S_REPORT;
            S_REPORT: if (out_free) n_state = S_CLEAR;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        in_ready     = 1'b0;
        out_load     = 1'b0;
        out_item     = '0;
        hist_we      = 1'b0;
        hist_waddr   = r_idx[BIN_AW-1:0];
        hist_wdata   = '0;
        hist_raddr   = scan_addr;
        scan_issue   = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = DIV_DW'(d);
        case (r_state)
            S_CLEAR: hist_we = 1'b1;
            S_IDLE: begin
                in_ready   = 1'b1;
                hist_raddr = i_in_item.pixel_in;
            end
            S_HUPD: begin
                hist_we    = counted;
                hist_waddr = r_item.pixel_in;
                hist_wdata = sat_inc(r_hist_q);
            end
            S_AOUT: begin
                out_load              = out_free;
                out_item.result_kind  = KIND_PIXEL;
                out_item.pixel_out    = r_lut_q;
            end
            S_SCAN:  scan_issue = !r_idx[BIN_AW];
            S_QSDIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_NW'(span_mag);
                div_divisor  = DIV_DW'(d);
            end
            S_QSWAIT: div_divisor = DIV_DW'(d);
            S_Q0DIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_NW'(num0_mag);
                div_divisor  = DIV_DW'(two_d);
            end
            S_Q0WAIT: div_divisor = DIV_DW'(two_d);
            S_REPORT: begin
                out_load                     = out_free;
                out_item.result_kind         = KIND_REPORT;
                out_item.low_cut             = r_lo;
                out_item.high_cut            = r_hi;
                out_item.full_range_fallback = r_fb;
                out_item.pixels_counted      = r_count;
            end
            default: ;
        endcase
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
        r_hist_q <= hist_mem[hist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL) lut_mem[r_idx[BIN_AW-1:0]] <= lut_wdata;
        if (accept) r_lut_q <= lut_mem[i_in_item.pixel_in];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= scan_issue;
            if (n_state != r_state) begin
                r_idx <= '0;
            end else if (r_state == S_SCAN && scan_end) begin
                r_idx <= '0;
            end else if (r_state == S_CLEAR || r_state == S_FILL || scan_issue) begin
                r_idx <= r_idx + (BIN_AW+1)'(1);
            end
            if (r_state == S_HUPD && counted) begin
                r_count <= sat_inc(r_count);
            end else if (r_state == S_REPORT && out_free) begin
                r_count <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= out_item;
        if (accept) r_item <= i_in_item;
        r_pend_addr <= scan_addr;

        case (r_state)
            S_HUPD: r_tsel <= 1'b0;
            S_TMUL: begin
                // Hold pct*count as the threshold, low side first
                if (r_tsel) r_thr_hi <= i_cfg.high_percent_hundredths * r_count;
                else        r_thr_lo <= i_cfg.low_percent_hundredths * r_count;
                r_tsel     <= ~r_tsel;
                r_dir      <= 1'b0;
                r_acc      <= ACC_SEED;
                r_lo_found <= 1'b0;
                r_hi_found <= 1'b0;
            end
            S_SCAN: begin
                if (scan_end) begin
                    r_dir <= 1'b1;
                    r_acc <= ACC_SEED;
                end else if (r_pend) begin
                    r_acc <= n_acc;
                    if (hit && !r_dir && !r_lo_found) begin
                        r_lo_found <= 1'b1;
                        r_lo_pos   <= r_pend_addr;
                    end
                    if (hit && r_dir && !r_hi_found) begin
                        r_hi_found <= 1'b1;
                        r_hi_pos   <= r_pend_addr;
                    end
                end
            end
            S_SETUP: begin
                if (!r_lo_found || !r_hi_found || (r_lo_pos >= r_hi_pos)) begin
                    r_fb <= 1'b1;
                    r_lo <= '0;
                    r_hi <= PIX_MAX;
                end else begin
                    r_fb <= 1'b0;
                    r_lo <= r_lo_pos;
                    r_hi <= r_hi_pos;
                end
            end
            S_QSWAIT: begin
                // Floor division of the target span by the cutoff distance
                if (div_done) begin
                    if (span[PIX_W] && div_rem != '0) begin
                        r_qs <= -($signed(10'(div_quot)) + 10'sd1);
                        r_rs <= d - div_rem[PIX_W-1:0];
                    end else if (span[PIX_W]) begin
                        r_qs <= -$signed(10'(div_quot));
                        r_rs <= '0;
                    end else begin
                        r_qs <= $signed(10'(div_quot));
                        r_rs <= div_rem[PIX_W-1:0];
                    end
                end
            end
            S_Q0WAIT: begin
                // Floor quotient and remainder of the map value at entry zero
                if (div_done) begin
                    if (num0[Q_W-1] && div_rem != '0) begin
                        r_q   <= -($signed(Q_W'(div_quot)) + Q_W'(1));
                        r_rem <= REM_W'(two_d) - div_rem[REM_W-1:0];
                    end else if (num0[Q_W-1]) begin
                        r_q   <= -$signed(Q_W'(div_quot));
                        r_rem <= '0;
                    end else begin
                        r_q   <= $signed(Q_W'(div_quot));
                        r_rem <= div_rem[REM_W-1:0];
                    end
                end
            end
            S_FILL: begin
                // Advance one entry: add the slope, carry when the remainder wraps
                if (rem_sum >= REM_W'(two_d)) begin
                    r_rem <= rem_sum - REM_W'(two_d);
                    r_q   <= r_q + qs_ext + Q_W'(1);
                end else begin
                    r_rem <= rem_sum;
                    r_q   <= r_q + qs_ext;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* rtl/percentile_contrast_stretch.sv */
// Percentile contrast stretch: per-frame histogram, cutoff search and 8-bit remap.
// A histogram-pass pixel reads the histogram RAM on the accepting edge; the
// saturated count is written back in the next cycle, unless the pixel is zero
// and zero skipping is on. An apply-pass pixel takes one stretch-table read,
// then the mapped pixel is placed in the output register. The last histogram
// pixel of a frame starts a burst during which no request is taken: the two
// threshold products, two scans of the histogram RAM (rising, then falling),
// two passes through the 20-bit serial divider for the slope and start value
// of the map, a table fill, the report, and a clearing pass of the histogram.
// After reset the same clearing pass runs before the first request is
// accepted. Results leave through a registered output stage; while a result
// waits there, one more apply-pass pixel is accepted and then held until the
// register frees. Applying before the first report reads a table that was
// never written. Depends on pcs_pkg, pcs_chan_if, pcs_div and pcs_core.
module percentile_contrast_stretch (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pcs_pkg::APB_AW-1:0] paddr,
    input  logic [pcs_pkg::APB_DW-1:0] pwdata,
    output logic [pcs_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    pcs_chan_if.sink                   i_pix,
    pcs_chan_if.source                 o_res
);
    import pcs_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_write;
    t_in_item   in_item;
    t_out_item  out_item;
    logic       core_in_ready;
    logic       core_out_valid;

    assign reg_idx   = paddr[APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register file: written on the access phase, reset to nominal 1% cutoffs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_percent_hundredths  <= PCT_W'(100);
            r_cfg.high_percent_hundredths <= PCT_W'(100);
            r_cfg.target_min              <= '0;
            r_cfg.target_max              <= PIX_MAX;
            r_cfg.skip_zero_pixels        <= 1'b0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_LOW_PCT:  r_cfg.low_percent_hundredths  <= pwdata[PCT_W-1:0];
                REG_HIGH_PCT: r_cfg.high_percent_hundredths <= pwdata[PCT_W-1:0];
                REG_TGT_MIN:  r_cfg.target_min              <= pwdata[PIX_W-1:0];
                REG_TGT_MAX:  r_cfg.target_max              <= pwdata[PIX_W-1:0];
                REG_SKIP:     r_cfg.skip_zero_pixels        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_LOW_PCT:  prdata = APB_DW'(r_cfg.low_percent_hundredths);
            REG_HIGH_PCT: prdata = APB_DW'(r_cfg.high_percent_hundredths);
            REG_TGT_MIN:  prdata = APB_DW'(r_cfg.target_min);
            REG_TGT_MAX:  prdata = APB_DW'(r_cfg.target_max);
            REG_SKIP:     prdata = APB_DW'(r_cfg.skip_zero_pixels);
            default:      prdata = '0;
        endcase
    end

    // Hold the request fields in the package layout
    assign in_item.mode       = i_pix.data.mode;
    assign in_item.pixel_in   = i_pix.data.pixel_in;
    assign in_item.frame_last = i_pix.data.frame_last;
    assign i_pix.ready        = core_in_ready;

    pcs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (core_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (core_out_valid),
        .i_out_ready (o_res.ready),
        .o_out_item  (out_item)
    );

    assign o_res.valid                    = core_out_valid;
    assign o_res.data.result_kind         = out_item.result_kind;
    assign o_res.data.pixel_out           = out_item.pixel_out;
    assign o_res.data.low_cut             = out_item.low_cut;
    assign o_res.data.high_cut            = out_item.high_cut;
    assign o_res.data.full_range_fallback = out_item.full_range_fallback;
    assign o_res.data.pixels_counted      = out_item.pixels_counted;

endmodule

/* tb/sv/percentile_contrast_stretch_tb.sv */
// Testbench for percentile_contrast_stretch: streams histogram and apply passes,
// predicts every mapped pixel and cutoff report, and checks each result in order.
// Depends on pcs_pkg, pcs_chan_if and the percentile_contrast_stretch RTL.
module percentile_contrast_stretch_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int FRAME_DRAIN    = 1600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    pcs_chan_if #(.T(t_in_item))  pix_ch ();
    pcs_chan_if #(.T(t_out_item)) res_ch ();

    percentile_contrast_stretch DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_pix(pix_ch.sink), .o_res(res_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // Shadow state of the block: histogram, count, table and registers
    logic [CNT_W-1:0] hist_bins [NUM_BINS];
    logic [CNT_W-1:0] frame_count;
    logic [PIX_W-1:0] map_table [NUM_BINS];
    t_cfg             cfg;

    t_out_item expected_results[$];
    int  error_count;
    int  idle_cycles;

    initial begin
        pix_ch.valid = 1'b0;
        pix_ch.data  = '0;
        res_ch.ready = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Recompute the map for the chosen cutoffs; halves round up, clamp to 0..255
    function automatic void build_map(input int lo, input int hi);
        longint d, span, n, num, r;
        d = hi - lo;
        span = longint'(cfg.target_max) - longint'(cfg.target_min);
        for (int v = 0; v < NUM_BINS; v++) begin
            n = longint'(v - lo) * span + longint'(cfg.target_min) * d;
            num = 2 * n + d;
            if (num < 0) r = 0;
            else begin
                r = num / (2 * d);
                if (r > 255) r = 255;
            end
            map_table[v] = r[7:0];
        end
    endfunction

    // Predict the result of one accepted request and queue it
    function automatic void predict_stretch(input t_in_item it);
        t_out_item res;
        longint thr, acc;
        int lo, hi;
        bit lo_hit, hi_hit, fb;
        res = '0;
        if (it.mode == MODE_APPLY) begin
            res.result_kind = KIND_PIXEL;
            res.pixel_out = map_table[it.pixel_in];
            expected_results.push_back(res);
            return;
        end
        if (!(cfg.skip_zero_pixels && it.pixel_in == 0)) begin
            if (hist_bins[it.pixel_in] < MAX_FRAME_PIXELS)
                hist_bins[it.pixel_in]++;
            if (frame_count < MAX_FRAME_PIXELS) frame_count++;
        end
        if (!it.frame_last) return;
        lo = 0; hi = 0; lo_hit = 0; hi_hit = 0;
        thr = (longint'(cfg.low_percent_hundredths) * frame_count) / 10000;
        acc = 0;
        for (int v = 0; v < NUM_BINS; v++) begin
            acc += hist_bins[v];
            if (acc >= thr) begin lo = v; lo_hit = 1; break; end
        end
        thr = (longint'(cfg.high_percent_hundredths) * frame_count) / 10000;
        acc = 0;
        for (int v = NUM_BINS - 1; v >= 0; v--) begin
            acc += hist_bins[v];
            if (acc >= thr) begin hi = v; hi_hit = 1; break; end
        end
        fb = !lo_hit || !hi_hit || lo >= hi;
        if (fb) begin lo = 0; hi = 255; end
        build_map(lo, hi);
        res.result_kind = KIND_REPORT;
        res.low_cut = lo[7:0];
        res.high_cut = hi[7:0];
        res.full_range_fallback = fb;
        res.pixels_counted = frame_count;
        expected_results.push_back(res);
        foreach (hist_bins[i]) hist_bins[i] = '0;
        frame_count = '0;
    endfunction

    // Send one request, hold it until accepted, then idle for a random gap
    task automatic send_pixel(input logic mode, input logic [7:0] px, input logic last);
        t_in_item it;
        int gap;
        it.mode = mode; it.pixel_in = px; it.frame_last = last;
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= it;
        do @(posedge i_clk); while (!pix_ch.ready);
        predict_stretch(it);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write one register at idle: setup then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_LOW_PCT:  cfg.low_percent_hundredths  = val[13:0];
            REG_HIGH_PCT: cfg.high_percent_hundredths = val[13:0];
            REG_TGT_MIN:  cfg.target_min = val[7:0];
            REG_TGT_MAX:  cfg.target_max = val[7:0];
            REG_SKIP:     cfg.skip_zero_pixels = val[0];
            default: ;
        endcase
    endtask

    // Drain outstanding results and let the block settle before a register write
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (FRAME_DRAIN) @(posedge i_clk);
    endtask

    task automatic set_config(input int lo_p, input int hi_p, input int tmin,
                              input int tmax, input int skip);
        wait_idle();
        write_reg(REG_LOW_PCT, lo_p);
        write_reg(REG_HIGH_PCT, hi_p);
        write_reg(REG_TGT_MIN, tmin);
        write_reg(REG_TGT_MAX, tmax);
        write_reg(REG_SKIP, skip);
    endtask

    function automatic logic [7:0] random_pixel(input int bias);
        case (bias)
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(60, 140));
            2: return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
            default: return ($urandom_range(0, 1)) ? 8'd0 : 8'd255;
        endcase
    endfunction

    // One frame: histogram pass of n pixels, then an apply pass of m pixels
    task automatic run_frame(input int n, input int m, input int bias);
        for (int i = 0; i < n; i++)
            send_pixel(MODE_HIST, random_pixel(bias), i == n - 1);
        for (int i = 0; i < m; i++)
            send_pixel(MODE_APPLY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed();
        // Default settings: extremes of the pixel field, a single-pixel frame
        send_pixel(MODE_HIST, 8'd0, 1'b0);
        send_pixel(MODE_HIST, 8'd255, 1'b0);
        send_pixel(MODE_HIST, 8'd128, 1'b1);
        send_pixel(MODE_APPLY, 8'd0, 1'b1);
        send_pixel(MODE_APPLY, 8'd255, 1'b0);
        send_pixel(MODE_APPLY, 8'd128, 1'b0);
        send_pixel(MODE_HIST, 8'd77, 1'b1);
        // Zero percent and inverted targets with zero skipping
        set_config(0, 0, 255, 0, 1);
        send_pixel(MODE_HIST, 8'd0, 1'b0);
        send_pixel(MODE_HIST, 8'd100, 1'b0);
        send_pixel(MODE_HIST, 8'd200, 1'b1);
        send_pixel(MODE_APPLY, 8'd150, 1'b0);
        send_pixel(MODE_APPLY, 8'd85, 1'b1);
        // Only zeros skipped: empty frame; percentages above 10000 never reached
        send_pixel(MODE_HIST, 8'd0, 1'b1);
        set_config(16383, 16383, 10, 20, 0);
        send_pixel(MODE_HIST, 8'd5, 1'b0);
        send_pixel(MODE_HIST, 8'd250, 1'b1);
        send_pixel(MODE_APPLY, 8'd5, 1'b0);
        set_config(10000, 10000, 0, 255, 0);
        send_pixel(MODE_HIST, 8'd40, 1'b0);
        send_pixel(MODE_HIST, 8'd90, 1'b1);
        send_pixel(MODE_APPLY, 8'd64, 1'b0);
    endtask

    task automatic test_random_frames();
        int frames;
        frames = 0;
        while (frames < 70) begin
            set_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 16383)
                                                 : $urandom_range(0, 2500),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 16383)
                                                 : $urandom_range(0, 2500),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 1));
            repeat (2) begin
                run_frame($urandom_range(1, 20), $urandom_range(3, 12),
                          $urandom_range(0, 3));
                frames++;
            end
        end
    endtask

    // Receiver stalls: per result draw a hold-off, sometimes none
    initial begin
        int stall;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(got.result_kind), 32'(0));
            end else begin
                want = expected_results.pop_front();
                if (got.result_kind != want.result_kind)
                    report_mismatch("result_kind", 32'(got.result_kind),
                                    32'(want.result_kind));
                if (got.pixel_out != want.pixel_out)
                    report_mismatch("pixel_out", 32'(got.pixel_out), 32'(want.pixel_out));
                if (got.low_cut != want.low_cut)
                    report_mismatch("low_cut", 32'(got.low_cut), 32'(want.low_cut));
                if (got.high_cut != want.high_cut)
                    report_mismatch("high_cut", 32'(got.high_cut), 32'(want.high_cut));
                if (got.full_range_fallback != want.full_range_fallback)
                    report_mismatch("full_range_fallback", 32'(got.full_range_fallback),
                                    32'(want.full_range_fallback));
                if (got.pixels_counted != want.pixels_counted)
                    report_mismatch("pixels_counted", 32'(got.pixels_counted),
                                    32'(want.pixels_counted));
            end
        end
    end

    // Watchdog: count cycles with no request moving on either channel and no register access
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("percentile_contrast_stretch_tb: done, errors");
            $finish;
        end
    end

    initial begin
        idle_cycles = 0;
        error_count = 0;
        frame_count = '0;
        foreach (hist_bins[i]) hist_bins[i] = '0;
        foreach (map_table[i]) map_table[i] = '0;
        cfg.low_percent_hundredths = 14'd100;
        cfg.high_percent_hundredths = 14'd100;
        cfg.target_min = 8'd0;
        cfg.target_max = 8'd255;
        cfg.skip_zero_pixels = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_frames();
        wait_idle();
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("percentile_contrast_stretch_tb: done, clean");
        end else begin
            $display("percentile_contrast_stretch_tb: done, errors");
        end
        $finish;
    end
endmodule
